// ----- rtl/tmfr_pkg.sv -----
// shared types, constants and font table for the text framebuffer renderer
// no dependencies; imported by tmfr_ctrl, tmfr_dp and the top level
package tmfr_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = PAGE_COUNT * DISPLAY_WIDTH;
    localparam int ADDR_W         = $clog2(STORE_BYTES);

    localparam int GLYPH_FIRST = 32;
    localparam int GLYPH_LAST  = 127;
    localparam int GLYPH_COLS  = 5;
    localparam int ADVANCE     = 6;
    localparam int LINE_STEP   = 8;
    localparam int NEWLINE     = 10;

    // two page bytes per glyph column
    localparam int STEP_COUNT = 2 * GLYPH_COLS;
    localparam int STEP_W     = $clog2(STEP_COUNT);
    localparam int STEP_LAST  = STEP_COUNT - 1;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_START = 2'd1,
        ACT_DRAW  = 2'd2,
        ACT_READ  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_DRAW,
        S_DRAIN,
        S_RD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic draw_step;
        logic read_issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic step_last;
    } t_dp_status;

    // one glyph per entry, column 0 in the top byte, bit 0 is the top row
    localparam logic [39:0] FONT_ROM [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
        40'h3649494936, 40'h464949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h4122140800, 40'h0201590906,
        40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415173,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0003070800, 40'h2054547840, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040403D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h4C9090907C, 40'h4464544C44, 40'h0008364100,
        40'h0000770000, 40'h0041360800, 40'h0201020402, 40'h0000000000
    };

    function automatic logic is_glyph(input logic [7:0] code);
        return (int'(code) >= GLYPH_FIRST) && (int'(code) <= GLYPH_LAST);
    endfunction

    // seven drawn rows of one glyph column, blank for codes outside the font
    function automatic logic [6:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
        logic [6:0]  idx;
        logic [39:0] row;
        logic [7:0]  bits;
        idx  = 7'(code - 8'(GLYPH_FIRST));
        row  = FONT_ROM[idx];
        bits = row[39 - 8 * int'(col) -: 8];
        if (!is_glyph(code)) begin
            bits = '0;
        end
        return bits[6:0];
    endfunction

    // rows of a page that lie on the display
    function automatic logic [7:0] row_mask(input logic [5:0] page);
        logic [7:0] m;
        for (int b = 0; b < 8; b++) begin
            m[b] = (int'(page) * 8 + b) < DISPLAY_HEIGHT;
        end
        return m;
    endfunction

endpackage

// ----- rtl/text_to_mono_framebuffer_renderer_unit.sv -----
// Renders 5x7 text into a 128x64 page-organized 1-bit frame store (1024 bytes, top row
// in bit 0 of each page byte) and reads bytes back; every beat in gives one beat out.
// A start beat goes straight to its result and a read beat issues one store read first.
// A character beat runs ten read-modify-write steps through the single-port-write store
// (five glyph columns, two page bytes each), then the drain state and the result. Newline
// and non-printable codes run the same sequence without writing. A clear beat sweeps the
// store one byte a cycle, and the same sweep runs after reset before the first beat is
// taken. The next beat is taken while a result still waits on the output.
module text_to_mono_framebuffer_renderer_unit
    import tmfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_origin_x,
    input  logic [7:0] i_origin_y,
    input  logic [7:0] i_char_code,
    input  logic [9:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tmfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    tmfr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_origin_x   (i_origin_x),
        .i_origin_y   (i_origin_y),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .o_status     (status),
        .o_read_data  (o_read_data)
    );

endmodule

// ----- rtl/tmfr_ctrl.sv -----
// sequencer for the text framebuffer renderer: handshakes, action dispatch, result slot
// depends on tmfr_pkg; drives tmfr_dp through t_dp_cmd
module tmfr_ctrl
    import tmfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (t_action'(i_action))
                        ACT_CLEAR: n_state = S_CLEAR;
                        ACT_START: n_state = S_RESP;
                        ACT_DRAW:  n_state = S_DRAW;
                        ACT_READ:  n_state = S_RD;
                        default:   n_state = S_RESP;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_RESP;
                end
            end
            S_DRAW: begin
                o_cmd.draw_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last read-modify-write lands here
            S_DRAIN: n_state = S_RESP;
            S_RD: begin
                o_cmd.read_issue = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_draw_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW && i_status.step_last) |=> (r_state == S_DRAIN))
        else $error("draw sequence did not end after last step");
    a_read_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_RESP))
        else $error("read did not move to response");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");
`endif

endmodule

// ----- rtl/tmfr_dp.sv -----
// datapath of the text framebuffer renderer: frame store, cursor, glyph read-modify-write
// depends on tmfr_pkg; commanded by tmfr_ctrl
module tmfr_dp
    import tmfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [1:0] i_action,
    input  logic [7:0] i_origin_x,
    input  logic [7:0] i_origin_y,
    input  logic [7:0] i_char_code,
    input  logic [9:0] i_read_index,
    output t_dp_status o_status,
    output logic [7:0] o_read_data
);

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_rd_data;

    logic [7:0]        r_cursor_col, r_cursor_row, r_line_start;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [STEP_W-1:0] r_step;
    logic              r_wr_pend;

    t_action           r_action;
    logic [7:0]        r_code, r_left, r_top;
    logic              r_glyph_ok;
    logic [9:0]        r_idx;
    logic [ADDR_W-1:0] r_wa;
    logic [7:0]        r_wbits;
    logic [7:0]        r_read_data;

    logic [2:0]        col;
    logic              hi;
    logic [15:0]       shifted;
    logic [8:0]        px;
    logic [5:0]        page;
    logic [7:0]        step_bits;
    logic [ADDR_W-1:0] step_addr;
    logic              step_we;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              idx_ok;

    // one page byte of one glyph column per step
    always_comb begin
        col       = r_step[STEP_W-1:1];
        hi        = r_step[0];
        shifted   = 16'(glyph_col(r_code, col)) << r_top[2:0];
        px        = 9'(r_left) + 9'(col);
        page      = 6'(r_top[7:3]) + 6'(hi);
        step_bits = (hi ? shifted[15:8] : shifted[7:0]) & row_mask(page);
        step_addr = ADDR_W'(32'(page) * 32'(DISPLAY_WIDTH) + 32'(px));
        step_we   = r_glyph_ok && (32'(px) < 32'(DISPLAY_WIDTH))
                    && (32'(page) < 32'(PAGE_COUNT));
        idx_ok    = 32'(r_idx) < 32'(STORE_BYTES);
        rd_en     = i_cmd.draw_step || i_cmd.read_issue;
        rd_addr   = i_cmd.draw_step ? step_addr : ADDR_W'(r_idx);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_col <= '0;
            r_cursor_row <= '0;
            r_line_start <= '0;
            r_clr_addr   <= '0;
            r_step       <= '0;
            r_wr_pend    <= 1'b0;
        end else begin
            r_wr_pend <= i_cmd.draw_step && step_we;
            if (i_cmd.capture) begin
                r_clr_addr <= '0;
                r_step     <= '0;
                if (t_action'(i_action) == ACT_START) begin
                    r_line_start <= i_origin_x;
                    r_cursor_col <= i_origin_x;
                    r_cursor_row <= i_origin_y;
                end else if (t_action'(i_action) == ACT_DRAW) begin
                    if (i_char_code == 8'(NEWLINE)) begin
                        r_cursor_col <= r_line_start;
                        r_cursor_row <= r_cursor_row + 8'(LINE_STEP);
                    end else begin
                        r_cursor_col <= r_cursor_col + 8'(ADVANCE);
                    end
                end
            end else begin
                if (i_cmd.clear_step) begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                if (i_cmd.draw_step) begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    // item and pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action   <= t_action'(i_action);
            r_code     <= i_char_code;
            r_left     <= r_cursor_col;
            r_top      <= r_cursor_row;
            r_glyph_ok <= is_glyph(i_char_code);
            r_idx      <= i_read_index;
        end
        r_wa    <= step_addr;
        r_wbits <= step_bits;
        if (i_cmd.load_out) begin
            r_read_data <= (r_action == ACT_READ && idx_ok) ? r_rd_data : 8'h00;
        end
    end

    // frame store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (r_wr_pend) begin
            r_mem[r_wa] <= r_rd_data | r_wbits;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_status.clear_last = (r_clr_addr == ADDR_W'(STORE_BYTES - 1));
    assign o_status.step_last  = (r_step == STEP_W'(STEP_LAST));
    assign o_read_data         = r_read_data;

`ifndef NO_ASSERTIONS
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.clear_step && r_wr_pend))
        else $error("clear and glyph write collide");
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (32'(r_wa) < 32'(STORE_BYTES)))
        else $error("glyph write outside store");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.draw_step |-> (32'(r_step) <= 32'(STEP_LAST)))
        else $error("draw step past last glyph byte");
`endif

endmodule
